// File: sv/slfifo_pkg.sv
`timescale 1ns / 1ps
// Package for the serial line discipline FIFO.
// Operation codes, character constants, result record and state encoding.
package slfifo_pkg;

	localparam int RING_DEPTH_DEF = 128;

	localparam logic [1:0] OP_RX   = 2'd0;
	localparam logic [1:0] OP_READ = 2'd1;
	localparam logic [1:0] OP_TX   = 2'd2;

	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CTRL_C = 8'h03;

	typedef struct packed {
		logic       read_valid;
		logic [7:0] read_byte;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       wake_readers;
		logic       interrupt_raised;
		logic       rx_dropped;
		logic       has_char;
		logic       last;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_LF   = 3'b100
	} state_t;

endpackage

// File: sv/serial_line_discipline_fifo.sv
`timescale 1ns / 1ps
// Serial line discipline with receive ring buffer.
// One transfer in, one or two transfers out; one registered output slot.
// Depends on slfifo_pkg.
// Receive, transmit and empty read register their result straight from the input;
// a buffered read goes through the ring memory read register, then the output register.
// Throughput: one item per cycle while the output slot is free; a data read holds the
// input until its byte is loaded, a transmitted LF for one extra result (CR then LF).
// Reset (arst_n low): pointers cleared, ring empty, link disabled; ring contents undefined.
module serial_line_discipline_fifo #(
	parameter int RING_DEPTH = slfifo_pkg::RING_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] operation,
	input  logic [7:0] data_byte,
	input  logic       foreground_present,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       read_valid,
	output logic [7:0] read_byte,
	output logic       tx_valid,
	output logic [7:0] tx_byte,
	output logic       wake_readers,
	output logic       interrupt_raised,
	output logic       rx_dropped,
	output logic       has_char,
	output logic       last
);

	localparam int PW = $clog2(RING_DEPTH);
	localparam logic [PW-1:0] PTR_MAX = PW'(RING_DEPTH - 1);

	logic [7:0] ring_mem [RING_DEPTH];

	slfifo_pkg::state_t state_q, state_d;
	logic [PW-1:0] rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
	logic          link_q;
	logic          out_valid_q, out_valid_d;
	slfifo_pkg::res_t res_q, res_d;
	logic [7:0]    rdata_s1;

	logic          in_xfer, out_free, mem_we, mem_re;
	logic [7:0]    rx_char;
	logic [PW-1:0] wr_adv, rd_adv;

	function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
		return (p == PTR_MAX) ? '0 : p + PW'(1);
	endfunction

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == slfifo_pkg::ST_IDLE) && out_free;
	assign in_xfer  = in_valid && in_ready;
	assign rx_char  = (data_byte == slfifo_pkg::CH_CR) ? slfifo_pkg::CH_LF : data_byte;
	assign wr_adv   = advance(wr_ptr_q);
	assign rd_adv   = advance(rd_ptr_q);

	always_comb begin
		state_d     = state_q;
		rd_ptr_d    = rd_ptr_q;
		wr_ptr_d    = wr_ptr_q;
		out_valid_d = out_valid_q && !out_ready;
		res_d       = res_q;
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		unique case (state_q)
			slfifo_pkg::ST_IDLE: begin
				if (in_xfer) begin
					res_d          = '0;
					res_d.last     = 1'b1;
					res_d.has_char = rd_ptr_q != wr_ptr_q;
					out_valid_d    = 1'b1;
					case (operation)
						slfifo_pkg::OP_RX: begin
							if (link_q) begin
								if (rx_char == slfifo_pkg::CH_CTRL_C && foreground_present) begin
									res_d.wake_readers     = 1'b1;
									res_d.interrupt_raised = 1'b1;
								end else if (wr_adv == rd_ptr_q) begin
									res_d.rx_dropped = 1'b1;
								end else begin
									mem_we             = 1'b1;
									wr_ptr_d           = wr_adv;
									res_d.wake_readers = 1'b1;
									res_d.has_char     = 1'b1;
								end
							end
						end
						slfifo_pkg::OP_READ: begin
							if (rd_ptr_q != wr_ptr_q) begin
								mem_re      = 1'b1;
								rd_ptr_d    = rd_adv;
								out_valid_d = 1'b0;
								state_d     = slfifo_pkg::ST_READ;
							end
						end
						slfifo_pkg::OP_TX: begin
							if (link_q) begin
								res_d.tx_valid = 1'b1;
								if (data_byte == slfifo_pkg::CH_LF) begin
									res_d.tx_byte = slfifo_pkg::CH_CR;
									res_d.last    = 1'b0;
									state_d       = slfifo_pkg::ST_LF;
								end else begin
									res_d.tx_byte = data_byte;
								end
							end
						end
						default: ;
					endcase
				end
			end
			slfifo_pkg::ST_READ: begin
				res_d            = '0;
				res_d.read_valid = 1'b1;
				res_d.read_byte  = rdata_s1;
				res_d.has_char   = rd_ptr_q != wr_ptr_q;
				res_d.last       = 1'b1;
				out_valid_d      = 1'b1;
				state_d          = slfifo_pkg::ST_IDLE;
			end
			slfifo_pkg::ST_LF: begin
				if (out_free) begin
					res_d.tx_byte = slfifo_pkg::CH_LF;
					res_d.last    = 1'b1;
					out_valid_d   = 1'b1;
					state_d       = slfifo_pkg::ST_IDLE;
				end
			end
			default: state_d = slfifo_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= slfifo_pkg::ST_IDLE;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			link_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_ptr_q    <= rd_ptr_d;
			wr_ptr_q    <= wr_ptr_d;
			out_valid_q <= out_valid_d;
			if (cfg_we) begin
				link_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	// ring memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[wr_ptr_q] <= rx_char;
		end
		if (mem_re) begin
			rdata_s1 <= ring_mem[rd_ptr_q];
		end
	end

	assign out_valid        = out_valid_q;
	assign read_valid       = res_q.read_valid;
	assign read_byte        = res_q.read_byte;
	assign tx_valid         = res_q.tx_valid;
	assign tx_byte          = res_q.tx_byte;
	assign wake_readers     = res_q.wake_readers;
	assign interrupt_raised = res_q.interrupt_raised;
	assign rx_dropped       = res_q.rx_dropped;
	assign has_char         = res_q.has_char;
	assign last             = res_q.last;

	a_read_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == slfifo_pkg::ST_READ |-> !out_valid_q)
		else $error("output slot busy during ring read");

	a_cr_before_lf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.last |-> res_q.tx_valid && res_q.tx_byte == slfifo_pkg::CH_CR)
		else $error("non-final result is not a CR");

	a_drop_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.rx_dropped |-> res_q.has_char)
		else $error("drop reported with empty ring");

	a_read_pops: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == slfifo_pkg::ST_READ |-> $past(rd_ptr_q) != rd_ptr_q)
		else $error("read without pointer advance");

	a_lf_follows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == slfifo_pkg::ST_LF |-> out_valid_q && !res_q.last)
		else $error("LF pending without CR shown");

endmodule
